### design/pcm_s2f_pkg.sv
// Package: register addresses and constants for the PCM sample to float converter.
package pcm_s2f_pkg;
  localparam int unsigned BpsW = 7;
  localparam logic [BpsW-1:0] BpsReset = 7'd16;
  localparam logic AddrBps = 1'b0;
  localparam logic AddrLe = 1'b1;

  typedef struct packed {
    logic          neg;
    logic [31:0]   mag;
    logic [7:0]    bias;
  } s2f_op_t;
endpackage

### design/pcm_sample_to_float_core.sv
// Top level: PCM sample to IEEE single-precision converter with APB configuration.
// An accepted input item passes through the input register and then the result register.
// Throughput: one item per cycle; the input and result registers form the only stages.
// The input stage advances whenever the result register is empty or being taken.
// Reset: synchronous, active high; clears valid flags, width 16, little endian.
module pcm_sample_to_float_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_bytes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] float_bits
);
  import pcm_s2f_pkg::*;

  logic [BpsW-1:0] bps;
  logic            le;
  logic            in_valid;
  logic [31:0]     in_data;
  logic            advance;
  s2f_op_t         op;
  logic [31:0]     fbits;
  logic [7:0]      b0, b1, b2, b3;
  logic [31:0]     raw;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrLe) ? {31'd0, le} : {25'd0, bps};

  always_ff @(posedge clk) begin
    if (rst) begin
      bps <= BpsReset;
      le <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == AddrBps) begin
        bps <= pwdata[BpsW-1:0];
      end else begin
        le <= pwdata[0];
      end
    end
  end

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      in_valid <= s_tvalid;
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_data <= s_tdata;
      m_tdata <= fbits;
    end
  end

  always_comb begin
    b0 = in_data[7:0];
    b1 = in_data[15:8];
    b2 = in_data[23:16];
    b3 = in_data[31:24];
    op.neg = 1'b0;
    op.mag = 32'd0;
    op.bias = 8'd0;
    raw = 32'd0;
    if (bps == 7'd8) begin
      op.neg = !b0[7];
      op.mag = b0[7] ? {24'd0, 1'b0, b0[6:0]} : (32'd128 - {24'd0, b0});
      op.bias = 8'd120;
    end else if (bps == 7'd16) begin
      raw = le ? {{16{b1[7]}}, b1, b0} : {{16{b0[7]}}, b0, b1};
      op.bias = 8'd112;
    end else if (bps == 7'd24) begin
      raw = le ? {{8{b2[7]}}, b2, b1, b0} : {{8{b0[7]}}, b0, b1, b2};
      op.bias = 8'd104;
    end else if (bps >= 7'd32) begin
      raw = le ? in_data : {b0, b1, b2, b3};
      op.bias = 8'd96;
    end
    if (bps != 7'd8) begin
      op.neg = raw[31];
      op.mag = raw[31] ? (32'd0 - raw) : raw;
    end
  end

  pcm_s2f_norm u_norm (
    .op    (op),
    .fbits (fbits)
  );
endmodule

### design/pcm_s2f_norm.sv
// Normalizer: magnitude and scale to single-precision bits, round to nearest even.
module pcm_s2f_norm (
  input  pcm_s2f_pkg::s2f_op_t op,
  output logic [31:0]          fbits
);
  import pcm_s2f_pkg::*;

  logic [4:0]  p;
  logic [31:0] mag;
  logic [31:0] sh;
  logic [24:0] keep;
  logic [7:0]  rest;
  logic        rnd;
  logic [7:0]  pe;
  logic [23:0] frac;

  always_comb begin
    mag = op.mag;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        p = 5'(i);
      end
    end
    sh = mag << (5'd31 - p);
    keep = {1'b0, sh[31:8]};
    rest = sh[7:0];
    rnd = rest[7] && ((rest[6:0] != 7'd0) || keep[0]);
    keep = keep + 25'(rnd);
    pe = 8'(p);
    frac = keep[23:0];
    if (keep[24]) begin
      pe = pe + 8'd1;
      frac = keep[24:1];
    end
    if (mag == 32'd0) begin
      fbits = 32'd0;
    end else begin
      fbits = {op.neg, pe + op.bias, frac[22:0]};
    end
  end
endmodule

### tb/pcm_sample_to_float_core_tb.sv
// Testbench: random and directed PCM samples checked against a float conversion predictor.
`timescale 1ns / 100ps

module pcm_sample_to_float_core_tb;
  import pcm_s2f_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:2]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] sample_bytes
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] float_bits

  pcm_sample_to_float_core dut (.*);

  always #10 clk = ~clk;

  logic [BpsW-1:0] width_cfg = BpsReset;
  logic            le_cfg = 1'b1;
  logic [31:0]     sample_q[$];
  logic [31:0]     float_q[$];
  int              send_idle = 12;
  int              recv_idle = 48;
  bit              failed = 0;
  int              quiet = 0;
  bit              in_taken = 0;

  function automatic logic [31:0] to_float(logic neg, logic [31:0] mag, int scale);
    int          p;
    logic [31:0] keep;
    logic [31:0] rem;
    logic [31:0] half;
    int          sh;
    if (mag == 0) return 32'h0;
    p = 0;
    for (int i = 31; i >= 0; i--) if (mag[i] && p == 0) p = i;
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 32'h0100_0000) begin
        keep = keep >> 1;
        p++;
      end
    end
    return {neg, 8'(p + 127 - scale), keep[22:0]};
  endfunction

  function automatic logic [31:0] from_signed(logic [31:0] v, int scale);
    return to_float(v[31], v[31] ? -v : v, scale);
  endfunction

  function automatic logic [31:0] sample_to_float(logic [31:0] w);
    logic [31:0] raw;
    if (width_cfg == 8) begin
      if (w[7]) return to_float(1'b0, w[7:0] - 128, 7);
      return to_float(1'b1, 128 - w[7:0], 7);
    end else if (width_cfg == 16) begin
      raw = le_cfg ? {{16{w[15]}}, w[15:0]} : {{16{w[7]}}, w[7:0], w[15:8]};
      return from_signed(raw, 15);
    end else if (width_cfg == 24) begin
      raw = le_cfg ? {{8{w[23]}}, w[23:0]} : {{8{w[7]}}, w[7:0], w[15:8], w[23:16]};
      return from_signed(raw, 23);
    end else if (width_cfg >= 32) begin
      raw = le_cfg ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
      return from_signed(raw, 31);
    end
    return 32'h0;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= s_tvalid && s_tready;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (s_tvalid && s_tready) begin
        float_q.push_back(sample_to_float(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        if (float_q.size() == 0) begin
          $error("float_bits: no item expected, actual %h", m_tdata);
          failed = 1;
        end else begin
          if (float_q[0] !== m_tdata) begin
            $error("float_bits: expected %h actual %h", float_q[0], m_tdata);
            failed = 1;
          end
          void'(float_q.pop_front());
        end
      end
      if (quiet >= 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (sample_q.size() == 0);
    @(posedge clk);
    while (s_tvalid || float_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= idx; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == AddrBps) width_cfg = val[BpsW-1:0];
    else le_cfg = val[0];
  endtask

  task automatic setup(logic [6:0] w, logic le);
    drain();
    write_reg(AddrBps, {25'd0, w});
    write_reg(AddrLe, {31'd0, le});
  endtask

  logic [6:0]  widths[] = '{8, 16, 24, 32, 127, 0, 12, 31, 64};
  logic [31:0] edges[] = '{32'h0, 32'hffffffff, 32'h80, 32'h7f, 32'h8000, 32'h0080,
                           32'h7fff, 32'h800000, 32'h000080, 32'h80000000,
                           32'h7fffffff, 32'h00000080, 32'h01000080, 32'h7fffff80};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (edges[i]) sample_q.push_back(edges[i]);
    drain();
    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 6) begin
        send_idle = 48; recv_idle = 12;
      end else if (ph == 12) begin
        send_idle = 0; recv_idle = 0;
      end else if (ph == 0) begin
        send_idle = 12; recv_idle = 48;
      end
      setup(widths[ph % 9], ph[0] ^ (ph >= 9));
      foreach (edges[i]) sample_q.push_back(edges[i]);
      for (int k = 0; k < 75; k++) begin
        case ($urandom_range(3))
          0: sample_q.push_back($urandom);
          1: sample_q.push_back({8'($urandom_range(255)), 16'h0, 8'($urandom_range(255))});
          2: sample_q.push_back($urandom & 32'h8000_00ff | 32'h0000_7f00);
          default: sample_q.push_back(32'h7fffff80 ^ $urandom_range(255));
        endcase
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
